// File: rtl/ute_pkg.sv
// shared constants, types and calendar helpers for the utc date to epoch seconds converter
package ute_pkg;

  localparam int unsigned YearSpan    = 256;
  localparam int unsigned YearW       = 8;
  localparam int unsigned MonthW      = 4;
  localparam int unsigned DayW        = 5;
  localparam int unsigned HourW       = 5;
  localparam int unsigned MinuteW     = 6;
  localparam int unsigned SecondW     = 6;
  localparam int unsigned SecsW       = 34;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned DayCntW     = 17;
  localparam int unsigned TodW        = 17;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned SecsPerDay  = 24 * 60 * 60;
  localparam logic [SecsW-1:0] SecsMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEpochYear   = 3'd0,
    CfgEpochMonth  = 3'd1,
    CfgEpochDay    = 3'd2,
    CfgEpochHour   = 3'd3,
    CfgEpochMinute = 3'd4,
    CfgEpochSecond = 3'd5
  } cfg_idx_e;

  typedef logic [DayCntW-1:0] day_cnt_t;
  typedef logic [TodW-1:0]    tod_t;

  function automatic logic [YearW-1:0] clamp_year(logic [YearW-1:0] y);
    logic [YearW-1:0] r;
    r = y;
    if (32'(y) >= YearSpan) begin
      r = YearW'(YearSpan - 1);
    end
    return r;
  endfunction

  function automatic logic [MonthW-1:0] clamp_month(logic [MonthW-1:0] m);
    return (m > MonthW'(11)) ? MonthW'(11) : m;
  endfunction

  // gregorian leap test on an offset from 1900 (offsets below 256 only)
  function automatic logic is_leap(logic [YearW-1:0] y);
    return (y[1:0] == 2'b00) && (y != YearW'(0)) && (y != YearW'(200));
  endfunction

  // days from 1900-01-01 to january 1 of the given year;
  // leap years in [1900, 1899+y]: multiples of four less 1900 and 2100
  function automatic day_cnt_t year_days(logic [YearW-1:0] y);
    logic [YearW+1:0] y3;
    logic [YearW-2:0] lp;
    y3 = {2'b00, y} + (YearW+2)'(3);
    lp = y3[YearW:2] - (YearW-1)'(y != YearW'(0)) - (YearW-1)'(y >= YearW'(201));
    return DayCntW'(y) * DayCntW'(DaysPerYear) + DayCntW'(lp);
  endfunction

  // days from january 1 to the first of the month
  function automatic logic [8:0] month_days(logic [MonthW-1:0] m, logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (m > MonthW'(1) && leap) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  function automatic day_cnt_t date_days(logic [YearW-1:0] y, logic [MonthW-1:0] m,
                                         logic [DayW-1:0] d);
    logic [YearW-1:0]  yc;
    logic [MonthW-1:0] mc;
    yc = clamp_year(y);
    mc = clamp_month(m);
    return year_days(yc) + DayCntW'(month_days(mc, is_leap(yc))) + DayCntW'(d);
  endfunction

  function automatic tod_t tod_secs(logic [HourW-1:0] h, logic [MinuteW-1:0] mi,
                                    logic [SecondW-1:0] s);
    return TodW'(h) * TodW'(3600) + TodW'(mi) * TodW'(60) + TodW'(s);
  endfunction

endpackage

// File: rtl/utc_date_to_epoch_seconds.sv
// utc calendar date and time to seconds since a configurable epoch
// the start transfer reaches the done strobe through the valid registers v1_q, v2_q, v3_q and done_q
// throughput: one conversion per cycle, busy_o never rises
// stages: day and time-of-day counts, differences, day multiply, sum and saturate
// reset clears the stage valid bits and loads the epoch 1970-01-01 00:00:00
module utc_date_to_epoch_seconds (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ute_pkg::YearW-1:0]     year_since_1900_i,
  input  logic [ute_pkg::MonthW-1:0]    month_index_i,
  input  logic [ute_pkg::DayW-1:0]      day_of_month_i,
  input  logic [ute_pkg::HourW-1:0]     hour_of_day_i,
  input  logic [ute_pkg::MinuteW-1:0]   minute_of_hour_i,
  input  logic [ute_pkg::SecondW-1:0]   second_of_minute_i,
  input  logic                          cfg_we_i,
  input  logic [ute_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ute_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          done_o,
  output logic [ute_pkg::SecsW-1:0]     epoch_seconds_o,
  output logic                          before_epoch_o
);
  import ute_pkg::*;

  // epoch registers
  logic [YearW-1:0]   ep_year_q;
  logic [MonthW-1:0]  ep_month_q;
  logic [DayW-1:0]    ep_day_q;
  logic [HourW-1:0]   ep_hour_q;
  logic [MinuteW-1:0] ep_minute_q;
  logic [SecondW-1:0] ep_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_year_q   <= YearW'(70);
      ep_month_q  <= '0;
      ep_day_q    <= DayW'(1);
      ep_hour_q   <= '0;
      ep_minute_q <= '0;
      ep_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgEpochYear:   ep_year_q   <= cfg_data_i[YearW-1:0];
        CfgEpochMonth:  ep_month_q  <= cfg_data_i[MonthW-1:0];
        CfgEpochDay:    ep_day_q    <= cfg_data_i[DayW-1:0];
        CfgEpochHour:   ep_hour_q   <= cfg_data_i[HourW-1:0];
        CfgEpochMinute: ep_minute_q <= cfg_data_i[MinuteW-1:0];
        CfgEpochSecond: ep_second_q <= cfg_data_i[SecondW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // stage valid bits
  logic v1_q, v2_q, v3_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  // stage 1: absolute day and second-of-day counts for target and epoch
  day_cnt_t tgt_days_q, ep_days_q;
  tod_t     tgt_tod_q, ep_tod_q;
  logic     yr_before_q;

  always_ff @(posedge clk_i) begin
    tgt_days_q  <= date_days(year_since_1900_i, month_index_i, day_of_month_i);
    ep_days_q   <= date_days(ep_year_q, ep_month_q, ep_day_q);
    tgt_tod_q   <= tod_secs(hour_of_day_i, minute_of_hour_i, second_of_minute_i);
    ep_tod_q    <= tod_secs(ep_hour_q, ep_minute_q, ep_second_q);
    yr_before_q <= clamp_year(year_since_1900_i) < clamp_year(ep_year_q);
  end

  // stage 2: differences and the early before-epoch decision
  logic signed [DayCntW:0] day_diff_d;
  logic signed [TodW:0]    tod_diff_d;
  logic [DayCntW-1:0]      days2_q;
  logic signed [TodW:0]    secs2_q;
  logic                    before2_q;

  assign day_diff_d = $signed({1'b0, tgt_days_q}) - $signed({1'b0, ep_days_q});
  assign tod_diff_d = $signed({1'b0, tgt_tod_q}) - $signed({1'b0, ep_tod_q});

  always_ff @(posedge clk_i) begin
    days2_q   <= day_diff_d[DayCntW-1:0];
    secs2_q   <= tod_diff_d;
    before2_q <= yr_before_q || day_diff_d[DayCntW]
                 || (day_diff_d == '0 && tod_diff_d[TodW]);
  end

  // stage 3: whole days to seconds
  logic [SecsW-1:0]     prod3_q;
  logic signed [TodW:0] secs3_q;
  logic                 before3_q;

  always_ff @(posedge clk_i) begin
    prod3_q   <= SecsW'(days2_q) * SecsW'(SecsPerDay);
    secs3_q   <= secs2_q;
    before3_q <= before2_q;
  end

  // stage 4: add the time-of-day difference, flag a negative total, saturate
  logic signed [SecsW+1:0] total_d;
  logic [SecsW-1:0]        secs_out_q;
  logic                    before_out_q;

  assign total_d = $signed({2'b00, prod3_q}) + (SecsW+2)'(secs3_q);

  always_ff @(posedge clk_i) begin
    if (before3_q || total_d[SecsW+1]) begin
      secs_out_q   <= '0;
      before_out_q <= 1'b1;
    end else begin
      secs_out_q   <= (total_d[SecsW]) ? SecsMax : total_d[SecsW-1:0];
      before_out_q <= 1'b0;
    end
  end

  assign done_o          = done_q;
  assign epoch_seconds_o = secs_out_q;
  assign before_epoch_o  = before_out_q;

`ifndef SYNTH
  a_before_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && before_epoch_o |-> epoch_seconds_o == '0)
    else $error("before-epoch result carries nonzero seconds");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("accepted transfer gave no result after four cycles");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v3_q) && $past(v2_q, 2))
    else $error("result strobe without an item in the pipeline");
`endif

endmodule

// File: verif/utc_date_to_epoch_seconds_tb.sv
// testbench for the utc date to epoch seconds converter: directed and random dates checked
`timescale 1ns / 100ps

module utc_date_to_epoch_seconds_tb;
  import ute_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam longint SecsCeiling = (longint'(1) << SecsW) - 1;

  typedef struct packed {
    logic [SecsW-1:0] seconds;
    logic             early;
  } stamp_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [YearW-1:0]    year_since_1900_i = '0;
  logic [MonthW-1:0]   month_index_i = '0;
  logic [DayW-1:0]     day_of_month_i = '0;
  logic [HourW-1:0]    hour_of_day_i = '0;
  logic [MinuteW-1:0]  minute_of_hour_i = '0;
  logic [SecondW-1:0]  second_of_minute_i = '0;
  logic                cfg_we_i = 1'b0;
  cfg_idx_e            cfg_index_i = CfgEpochYear;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                done_o;
  logic [SecsW-1:0]    epoch_seconds_o;
  logic                before_epoch_o;

  // local copy of the epoch registers, indexed by register
  logic [CfgDataW-1:0] epoch_reg [6] = '{8'd70, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0};
  stamp_t              stamp_q [$];
  stamp_t              want_stamp;
  int unsigned         fault_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         gap_pct = 0;

  utc_date_to_epoch_seconds DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .year_since_1900_i  (year_since_1900_i),
    .month_index_i      (month_index_i),
    .day_of_month_i     (day_of_month_i),
    .hour_of_day_i      (hour_of_day_i),
    .minute_of_hour_i   (minute_of_hour_i),
    .second_of_minute_i (second_of_minute_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .epoch_seconds_o    (epoch_seconds_o),
    .before_epoch_o     (before_epoch_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CfgDataW-1:0] reg_mask(cfg_idx_e idx);
    case (idx)
      CfgEpochYear:   return 8'hFF;
      CfgEpochMonth:  return 8'h0F;
      CfgEpochDay:    return 8'h1F;
      CfgEpochHour:   return 8'h1F;
      default:        return 8'h3F;
    endcase
  endfunction

  function automatic bit gregorian_leap(longint yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // leap years from year 1 up to and including yr
  function automatic longint leaps_through(longint yr);
    return yr / 4 - yr / 100 + yr / 400;
  endfunction

  function automatic longint first_of_month(longint yr, longint mon);
    longint day_offset [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    longint d;
    d = day_offset[mon];
    if (mon > 1 && gregorian_leap(yr)) begin
      d = d + 1;
    end
    return d;
  endfunction

  function automatic stamp_t epoch_distance(logic [YearW-1:0] y, logic [MonthW-1:0] m,
                                            logic [DayW-1:0] d, logic [HourW-1:0] h,
                                            logic [MinuteW-1:0] mi, logic [SecondW-1:0] s);
    longint ty, tm, ey, em, days, secs, total;
    longint tday, thr, tmin, tsec, eday, ehr, emin, esec;
    stamp_t r;
    ty = longint'(y);
    tm = longint'(m);
    tday = longint'(d);
    thr = longint'(h);
    tmin = longint'(mi);
    tsec = longint'(s);
    ey = longint'(epoch_reg[CfgEpochYear]);
    em = longint'(epoch_reg[CfgEpochMonth]);
    eday = longint'(epoch_reg[CfgEpochDay]);
    ehr = longint'(epoch_reg[CfgEpochHour]);
    emin = longint'(epoch_reg[CfgEpochMinute]);
    esec = longint'(epoch_reg[CfgEpochSecond]);
    if (ty >= longint'(YearSpan)) ty = longint'(YearSpan) - 1;
    if (ey >= longint'(YearSpan)) ey = longint'(YearSpan) - 1;
    if (tm > 11) tm = 11;
    if (em > 11) em = 11;
    r.early = 1'b0;
    total = 0;
    if (ty < ey) begin
      r.early = 1'b1;
    end else begin
      days = (ty - ey) * 365 + leaps_through(ty + 1899) - leaps_through(ey + 1899);
      days = days - first_of_month(ey + 1900, em) + first_of_month(ty + 1900, tm);
      days = days + tday - eday;
      secs = ((thr - ehr) * 60 + (tmin - emin)) * 60 + (tsec - esec);
      if (days < 0 || (days == 0 && secs < 0)) begin
        r.early = 1'b1;
      end else begin
        total = days * 86400 + secs;
        if (total < 0) r.early = 1'b1;
        else if (total > SecsCeiling) total = SecsCeiling;
      end
    end
    if (r.early) total = 0;
    r.seconds = total[SecsW-1:0];
    return r;
  endfunction

  // a transfer completes at an edge with start high and busy low
  task automatic send_item(logic [YearW-1:0] y, logic [MonthW-1:0] m, logic [DayW-1:0] d,
                           logic [HourW-1:0] h, logic [MinuteW-1:0] mi,
                           logic [SecondW-1:0] s);
    logic busy_seen;
    start_i <= 1'b1;
    year_since_1900_i <= y;
    month_index_i <= m;
    day_of_month_i <= d;
    hour_of_day_i <= h;
    minute_of_hour_i <= mi;
    second_of_minute_i <= s;
    do begin
      @(negedge clk_i);
      busy_seen = busy_o;
      @(posedge clk_i);
    end while (busy_seen !== 1'b0);
    stamp_q.push_back(epoch_distance(y, m, d, h, mi, s));
    // each following cycle idles with probability gap_pct
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic settle_pipeline;
    start_i <= 1'b0;
    while (stamp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    epoch_reg[idx] = data & reg_mask(idx);
  endtask

  // write all six registers; noisy puts random bits above each register's width
  task automatic set_epoch(logic [7:0] y, logic [7:0] m, logic [7:0] d, logic [7:0] h,
                           logic [7:0] mi, logic [7:0] s, bit noisy);
    logic [CfgDataW-1:0] vals [6];
    cfg_idx_e idx;
    vals = '{y, m, d, h, mi, s};
    for (int i = 0; i < 6; i++) begin
      idx = cfg_idx_e'(i);
      if (noisy) vals[i] = vals[i] | (CfgDataW'($urandom()) & ~reg_mask(idx));
      cfg_write(idx, vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly in range, now and then anywhere in the field
  function automatic int unsigned spread(int unsigned lo, int unsigned hi, int unsigned top);
    if ($urandom_range(99) < 10) return $urandom_range(top, 0);
    return $urandom_range(hi, lo);
  endfunction

  task automatic test_default_epoch;
    send_item(70, 0, 1, 0, 0, 0);
    send_item(69, 11, 31, 23, 59, 59);
    send_item(0, 0, 1, 0, 0, 0);
    send_item(255, 11, 31, 23, 59, 60);
    send_item(255, 15, 31, 31, 63, 63);
    send_item(100, 1, 29, 12, 0, 0);
    send_item(200, 2, 1, 0, 0, 0);
    send_item(104, 12, 25, 6, 30, 0);
    send_item(104, 15, 1, 0, 0, 0);
    send_item(70, 0, 0, 0, 0, 0);
    send_item(70, 0, 1, 0, 0, 60);
    send_item(70, 0, 1, 23, 59, 59);
    send_item(71, 1, 31, 0, 0, 0);
    send_item(70, 0, 1, 31, 0, 0);
    settle_pipeline();
  endtask

  task automatic test_epoch_extremes;
    set_epoch(0, 0, 1, 0, 0, 0, 1'b0);
    send_item(0, 0, 1, 0, 0, 0);
    send_item(255, 11, 31, 23, 59, 60);
    send_item(255, 15, 31, 31, 63, 63);
    send_item(0, 0, 0, 23, 59, 59);
    settle_pipeline();
    set_epoch(255, 11, 31, 23, 59, 60, 1'b0);
    send_item(255, 11, 31, 23, 59, 60);
    send_item(255, 11, 31, 23, 59, 59);
    send_item(254, 11, 31, 23, 59, 60);
    send_item(255, 15, 31, 31, 63, 63);
    settle_pipeline();
    set_epoch(255, 15, 31, 31, 63, 63, 1'b1);
    send_item(255, 11, 31, 31, 63, 63);
    send_item(255, 11, 31, 0, 0, 0);
    settle_pipeline();
  endtask

  // a later day whose time of day pulls the total below zero, to exactly zero and just above it
  task automatic test_negative_total;
    set_epoch(70, 0, 0, 31, 63, 63, 1'b0);
    send_item(70, 0, 1, 0, 0, 0);
    send_item(70, 0, 1, 8, 4, 3);
    send_item(70, 0, 1, 8, 4, 4);
    settle_pipeline();
  endtask

  task automatic random_epoch;
    logic [7:0] y;
    logic [7:0] m;
    y = 8'(($urandom_range(3) == 0) ? $urandom_range(255, 0) : $urandom_range(200, 0));
    m = 8'(spread(0, 11, 15));
    set_epoch(y, m, 8'(spread(1, 31, 31)), 8'(spread(0, 23, 31)), 8'(spread(0, 59, 63)),
              8'(spread(0, 60, 63)), $urandom_range(3) == 0);
  endtask

  // about a third of the dates sit close to the epoch so the boundary gets hit
  task automatic random_item;
    int yy;
    logic [YearW-1:0] y;
    logic [MonthW-1:0] m;
    logic [DayW-1:0] d;
    y = YearW'($urandom_range(255, 0));
    m = MonthW'(spread(0, 11, 15));
    d = DayW'(spread(1, 31, 31));
    if ($urandom_range(99) < 35) begin
      yy = int'(epoch_reg[CfgEpochYear]) + int'($urandom_range(2, 0)) - 1;
      if (yy < 0) yy = 0;
      if (yy > 255) yy = 255;
      y = YearW'(yy);
      if ($urandom_range(1) != 0) m = epoch_reg[CfgEpochMonth][MonthW-1:0];
      if ($urandom_range(1) != 0) d = epoch_reg[CfgEpochDay][DayW-1:0];
    end
    send_item(y, m, d, HourW'(spread(0, 23, 31)), MinuteW'(spread(0, 59, 63)),
              SecondW'(spread(0, 60, 63)));
  endtask

  task automatic test_random_traffic;
    int unsigned pct_list [3];
    pct_list = '{37, 83, 0};
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = pct_list[phase];
      repeat (4) begin
        settle_pipeline();
        random_epoch();
        repeat (100) random_item();
      end
    end
    gap_pct = 0;
    settle_pipeline();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (stamp_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result: seconds %0d before_epoch %0b",
                   epoch_seconds_o, before_epoch_o);
        end
      end else begin
        want_stamp = stamp_q.pop_front();
        if (epoch_seconds_o !== want_stamp.seconds || before_epoch_o !== want_stamp.early) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: seconds exp %0d got %0d, before_epoch exp %0b got %0b",
                     want_stamp.seconds, epoch_seconds_o, want_stamp.early, before_epoch_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_epoch();
    test_epoch_extremes();
    test_negative_total();
    test_random_traffic();
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
